// ----- hdl/mahs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mahs_pkg;

   // sync pattern
   localparam logic [7:0] SyncByte = 8'hFF;
   localparam logic [7:0] SyncMask = 8'hE0;

   // configuration register indexes
   localparam int unsigned CsrIndexWidth = 4;
   localparam logic [CsrIndexWidth-1:0] CsrMemberOffset   = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCompressedSize = 4'd1;

   // version codes as reported
   localparam logic [1:0] VerMpeg1    = 2'd0;
   localparam logic [1:0] VerMpeg2    = 2'd1;
   localparam logic [1:0] VerMpeg25   = 2'd2;
   localparam logic [1:0] VerReserved = 2'd3;

   // version field codes in the header byte
   localparam logic [1:0] HdrVerMpeg25 = 2'd0;
   localparam logic [1:0] HdrVerMpeg2  = 2'd2;
   localparam logic [1:0] HdrVerMpeg1  = 2'd3;

   localparam logic [1:0] LayerReserved = 2'd0;

   // divider: 35-bit dividend (size * 8), one quotient bit per cycle
   localparam int unsigned DivSteps      = 35;
   localparam int unsigned DivCountWidth = $clog2(DivSteps);

   localparam logic [8:0] RateV1 [3][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
   };

   localparam logic [8:0] RateV2 [3][16] = '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   typedef enum logic [1:0] {
      ScanSearch = 2'd0,
      ScanSynced = 2'd1,
      ScanDone   = 2'd2
   } scan_phase_type;

   typedef enum logic [1:0] {
      CtrlIdle   = 2'd0,
      CtrlDivide = 2'd1,
      CtrlHold   = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic step;     // byte word accepted this cycle
      logic div_run;  // advance divider one bit
   } dp_cmd_type;

   typedef struct packed {
      logic emit;      // current byte produces a result
      logic need_div;  // that result needs a play length division
      logic div_last;  // divider on its final step
   } dp_status_type;

   function automatic logic [8:0] rate_lookup(input logic [1:0] ver,
                                              input logic [1:0] lay,
                                              input logic [3:0] idx);
      logic [8:0] r;
      logic [1:0] row;
      r   = '0;
      row = 2'(lay - 2'd1);
      if (lay != LayerReserved) begin
         case (ver)
            VerMpeg1:            r = RateV1[row][idx];
            VerMpeg2, VerMpeg25: r = RateV2[row][idx];
            default:             r = '0;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mahs_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mahs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/mahs_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mahs_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] header_position;
   logic [1:0]  version;
   logic [1:0]  layer;
   logic [8:0]  bitrate_kbps;
   logic [31:0] play_length_ms;

   modport source (output valid, output status, output header_position, output version,
                   output layer, output bitrate_kbps, output play_length_ms, input ready);
   modport sink   (input valid, input status, input header_position, input version,
                   input layer, input bitrate_kbps, input play_length_ms, output ready);
endinterface

`default_nettype wire

// ----- hdl/mahs_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mahs_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mahs_pkg::CsrIndexWidth-1:0] index;
   logic [31:0]                        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/mahs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mahs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mahs_pkg::dp_cmd_type               cmd,
   output mahs_pkg::dp_status_type            stat,
   input  logic [7:0]                         data_byte,
   input  logic                               last_byte,
   input  logic                               csr_write,
   input  logic [mahs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                        csr_data,
   output logic                               rsp_status,
   output logic [31:0]                        rsp_header_position,
   output logic [1:0]                         rsp_version,
   output logic [1:0]                         rsp_layer,
   output logic [8:0]                         rsp_bitrate_kbps,
   output logic [31:0]                        rsp_play_length_ms
);

   localparam int unsigned DivW = mahs_pkg::DivCountWidth;

   // configuration
   logic [31:0] member_offset_ff;
   logic [31:0] compressed_size_ff;

   // scan state
   mahs_pkg::scan_phase_type phase_ff, phase_in;
   logic [7:0]  prev_byte_ff;
   logic        have_prev_ff;
   logic [31:0] byte_index_ff;
   logic [31:0] sync_index_ff, sync_index_in;
   logic [1:0]  held_version_ff, held_version_in;
   logic [1:0]  held_layer_ff, held_layer_in;

   // result and divider
   logic        status_ff;
   logic [31:0] position_ff;
   logic [1:0]  version_ff;
   logic [1:0]  layer_ff;
   logic [8:0]  bitrate_ff;
   logic [34:0] num_ff, num_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  rem_divisor_ff;
   logic [DivW-1:0] count_ff, count_in;

   logic       sync_hit;
   logic       is_synced;
   logic [1:0] mapped_version;
   logic [1:0] mapped_layer;
   logic [8:0] rate;
   logic [9:0] trial;
   logic [9:0] diff;
   logic       ge;

   always_comb begin
      sync_hit  = (phase_ff == mahs_pkg::ScanSearch) && have_prev_ff
                  && (prev_byte_ff == mahs_pkg::SyncByte)
                  && ((data_byte & mahs_pkg::SyncMask) == mahs_pkg::SyncMask);
      is_synced = (phase_ff == mahs_pkg::ScanSynced);

      case (data_byte[4:3])
         mahs_pkg::HdrVerMpeg1:  mapped_version = mahs_pkg::VerMpeg1;
         mahs_pkg::HdrVerMpeg2:  mapped_version = mahs_pkg::VerMpeg2;
         mahs_pkg::HdrVerMpeg25: mapped_version = mahs_pkg::VerMpeg25;
         default:                mapped_version = mahs_pkg::VerReserved;
      endcase
      // layer field counts down: 3 is layer I
      mapped_layer = (data_byte[2:1] == 2'd0) ? mahs_pkg::LayerReserved
                                               : 2'(3'd4 - {1'b0, data_byte[2:1]});

      rate = mahs_pkg::rate_lookup(held_version_ff, held_layer_ff, data_byte[7:4]);

      stat.emit     = is_synced || ((phase_ff == mahs_pkg::ScanSearch) && last_byte);
      stat.need_div = is_synced && (rate != 9'd0);
      stat.div_last = (count_ff == DivW'(mahs_pkg::DivSteps - 1));
   end

   // next scan state for an accepted byte, before the member-end rearm
   always_comb begin
      phase_in        = phase_ff;
      sync_index_in   = sync_index_ff;
      held_version_in = held_version_ff;
      held_layer_in   = held_layer_ff;
      case (phase_ff)
         mahs_pkg::ScanSearch: begin
            if (sync_hit) begin
               phase_in        = mahs_pkg::ScanSynced;
               sync_index_in   = byte_index_ff - 32'd1;
               held_version_in = mapped_version;
               held_layer_in   = mapped_layer;
            end
         end
         mahs_pkg::ScanSynced: phase_in = mahs_pkg::ScanDone;
         default:              phase_in = mahs_pkg::ScanDone;
      endcase
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, num_ff[34]};
      diff  = trial - {1'b0, rem_divisor_ff};
      ge    = (trial >= {1'b0, rem_divisor_ff});
      rem_in   = ge ? diff[8:0] : trial[8:0];
      num_in   = {num_ff[33:0], ge};
      count_in = count_ff + DivW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_offset_ff   <= '0;
         compressed_size_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            mahs_pkg::CsrMemberOffset:   member_offset_ff   <= csr_data;
            mahs_pkg::CsrCompressedSize: compressed_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= mahs_pkg::ScanSearch;
         prev_byte_ff    <= '0;
         have_prev_ff    <= 1'b0;
         byte_index_ff   <= '0;
         sync_index_ff   <= '0;
         held_version_ff <= '0;
         held_layer_ff   <= '0;
      end else if (cmd.step) begin
         if (last_byte) begin
            phase_ff        <= mahs_pkg::ScanSearch;
            prev_byte_ff    <= '0;
            have_prev_ff    <= 1'b0;
            byte_index_ff   <= '0;
            sync_index_ff   <= '0;
            held_version_ff <= '0;
            held_layer_ff   <= '0;
         end else begin
            phase_ff        <= phase_in;
            prev_byte_ff    <= data_byte;
            have_prev_ff    <= 1'b1;
            byte_index_ff   <= byte_index_ff + 32'd1;
            sync_index_ff   <= sync_index_in;
            held_version_ff <= held_version_in;
            held_layer_ff   <= held_layer_in;
         end
      end
   end

   // result word loaded only in idle; divide alters only play length
   always_ff @(posedge clock) begin
      if (cmd.step && stat.emit) begin
         status_ff   <= !is_synced;
         position_ff <= is_synced ? (member_offset_ff + sync_index_ff) : 32'd0;
         version_ff  <= is_synced ? held_version_ff : 2'd0;
         layer_ff    <= is_synced ? held_layer_ff : 2'd0;
         bitrate_ff  <= is_synced ? rate : 9'd0;
         num_ff      <= stat.need_div ? {compressed_size_ff, 3'b000} : 35'd0;
         rem_ff      <= '0;
         rem_divisor_ff <= rate;
         count_ff    <= '0;
      end else if (cmd.div_run) begin
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_header_position = position_ff;
   assign rsp_version         = version_ff;
   assign rsp_layer           = layer_ff;
   assign rsp_bitrate_kbps    = bitrate_ff;
   assign rsp_play_length_ms  = num_ff[31:0];

endmodule

`default_nettype wire

// ----- hdl/mahs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mahs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mahs_pkg::dp_cmd_type    cmd,
   input  mahs_pkg::dp_status_type stat
);

   mahs_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mahs_pkg::CtrlIdle: begin
            if (req_valid && stat.emit) begin
               state_in = stat.need_div ? mahs_pkg::CtrlDivide : mahs_pkg::CtrlHold;
            end
         end
         mahs_pkg::CtrlDivide: begin
            if (stat.div_last) begin
               state_in = mahs_pkg::CtrlHold;
            end
         end
         mahs_pkg::CtrlHold: begin
            if (rsp_ready) begin
               state_in = mahs_pkg::CtrlIdle;
            end
         end
         default: state_in = mahs_pkg::CtrlIdle;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.step    = 1'b0;
      cmd.div_run = 1'b0;
      case (state_ff)
         mahs_pkg::CtrlIdle: begin
            req_ready = 1'b1;
            cmd.step  = req_valid;
         end
         mahs_pkg::CtrlDivide: cmd.div_run = 1'b1;
         mahs_pkg::CtrlHold:   rsp_valid   = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mahs_pkg::CtrlIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mpeg_audio_header_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake    word
// req_chan  in   valid/ready  data_byte[7:0], last_byte
// rsp_chan  out  valid/ready  status, header_position[31:0], version[1:0], layer[1:0],
//                             bitrate_kbps[8:0], play_length_ms[31:0]
// csr_chan  in   valid/ready  index[3:0] (0 member_offset, 1 compressed_size), data[31:0]
//
// Bytes that cause no result are taken one per cycle.
// A byte that ends a member without a header, or a found header with a zero bitrate,
// shows its result the next cycle; a found header with a nonzero bitrate first runs
// the bit-serial divider for the play length.
// While a result is being formed or waits on rsp_chan.ready no byte is taken.
// Synchronous reset clears scan state, csr registers and controller; csr always ready.

module mpeg_audio_header_scanner (
   input  logic        clock,
   input  logic        reset,
   mahs_req_if.sink    req_chan,
   mahs_rsp_if.source  rsp_chan,
   mahs_csr_if.sink    csr_chan
);

   mahs_pkg::dp_cmd_type    cmd;
   mahs_pkg::dp_status_type stat;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   // sequencer: idle (take bytes) -> divide (only when needed) -> hold result
   mahs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // sync search, header decode, bitrate table, divider, result word
   mahs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .data_byte           (req_chan.data_byte),
      .last_byte           (req_chan.last_byte),
      .csr_write           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .rsp_status          (rsp_chan.status),
      .rsp_header_position (rsp_chan.header_position),
      .rsp_version         (rsp_chan.version),
      .rsp_layer           (rsp_chan.layer),
      .rsp_bitrate_kbps    (rsp_chan.bitrate_kbps),
      .rsp_play_length_ms  (rsp_chan.play_length_ms)
   );

endmodule

`default_nettype wire

// ----- tb/mahs_tb_pkg.sv -----
`timescale 1ns / 1ps

package mahs_tb_pkg;
   import mahs_pkg::*;

   localparam logic StFound   = 1'b0;
   localparam logic StMissing = 1'b1;

   typedef struct packed {
      logic        status;
      logic [31:0] header_position;
      logic [1:0]  version;
      logic [1:0]  layer;
      logic [8:0]  bitrate_kbps;
      logic [31:0] play_length_ms;
   } scan_result_type;

   // kbps by [layer-1][index], MPEG-1 and MPEG-2/2.5
   localparam int unsigned KbpsV1 [3][16] = '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
   };
   localparam int unsigned KbpsV2 [3][16] = '{
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
   };

   class scanner_scoreboard;
      logic [31:0]     offset_reg;
      logic [31:0]     size_reg;
      logic [7:0]      prev_byte;
      logic            have_prev;
      scan_phase_type  phase;
      logic [31:0]     byte_count;
      logic [31:0]     sync_pos;
      logic [1:0]      ver_code;
      logic [1:0]      layer_code;
      scan_result_type expected_q[$];
      int              errors;
      int              found_seen;
      int              missing_seen;

      function new();
         offset_reg   = '0;
         size_reg     = '0;
         errors       = 0;
         found_seen   = 0;
         missing_seen = 0;
         rearm();
      endfunction

      function void rearm();
         prev_byte  = '0;
         have_prev  = 1'b0;
         phase      = ScanSearch;
         byte_count = '0;
         sync_pos   = '0;
         ver_code   = '0;
         layer_code = '0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [31:0] value);
         case (idx)
            CsrMemberOffset:   offset_reg = value;
            CsrCompressedSize: size_reg   = value;
            default: ;
         endcase
      endfunction

      function logic [8:0] kbps(logic [1:0] ver, logic [1:0] lay, logic [3:0] idx);
         if (lay == LayerReserved) return '0;
         case (ver)
            VerMpeg1:            return 9'(KbpsV1[int'(lay) - 1][idx]);
            VerMpeg2, VerMpeg25: return 9'(KbpsV2[int'(lay) - 1][idx]);
            default:             return '0;
         endcase
      endfunction

      // one accepted byte word; queues the result it causes, if any
      function void note_byte(logic [7:0] b, logic is_last);
         scan_result_type r;
         logic [8:0]      rate;
         logic [34:0]     bits;
         r = '0;
         case (phase)
            ScanSearch: begin
               if (have_prev && prev_byte == SyncByte && (b & SyncMask) == SyncMask) begin
                  case (b[4:3])
                     HdrVerMpeg1:  ver_code = VerMpeg1;
                     HdrVerMpeg2:  ver_code = VerMpeg2;
                     HdrVerMpeg25: ver_code = VerMpeg25;
                     default:      ver_code = VerReserved;
                  endcase
                  layer_code = (b[2:1] == 2'd0) ? LayerReserved : 2'(4 - int'(b[2:1]));
                  sync_pos   = byte_count - 32'd1;
                  phase      = ScanSynced;
               end
               if (is_last) begin
                  r.status = StMissing;
                  expected_q.push_back(r);
               end
            end
            ScanSynced: begin
               rate              = kbps(ver_code, layer_code, b[7:4]);
               bits              = {size_reg, 3'b000};
               r.status          = StFound;
               r.header_position = offset_reg + sync_pos;
               r.version         = ver_code;
               r.layer           = layer_code;
               r.bitrate_kbps    = rate;
               if (rate != '0) r.play_length_ms = 32'(bits / 35'(rate));
               expected_q.push_back(r);
               phase = ScanDone;
            end
            default: ;
         endcase
         if (is_last) begin
            rearm();
         end else begin
            prev_byte  = b;
            have_prev  = 1'b1;
            byte_count = byte_count + 32'd1;
         end
      endfunction

      function bit same(string what, logic [31:0] want, logic [31:0] got);
         if (want === got) return 1'b1;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         return 1'b0;
      endfunction

      function void check(scan_result_type got);
         scan_result_type want;
         bit              ok;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, status %0d position 0x%0h",
                     $time, got.status, got.header_position);
            return;
         end
         want = expected_q.pop_front();
         ok = same("status", 32'(want.status), 32'(got.status))
            & same("header_position", want.header_position, got.header_position)
            & same("version", 32'(want.version), 32'(got.version))
            & same("layer", 32'(want.layer), 32'(got.layer))
            & same("bitrate_kbps", 32'(want.bitrate_kbps), 32'(got.bitrate_kbps))
            & same("play_length_ms", want.play_length_ms, got.play_length_ms);
         if (!ok) errors++;
         if (want.status == StFound) found_seen++;
         else missing_seen++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

// ----- tb/tb_mpeg_audio_header_scanner.sv -----
`timescale 1ns / 1ps

module tb_mpeg_audio_header_scanner;
   import mahs_pkg::*;
   import mahs_tb_pkg::*;

   // counted (non-ignored) bytes per random phase
   localparam int unsigned BytesPerPhase = 210;
   // leave margin for the divider and result setup before touching csr
   localparam int unsigned SettleCycles  = 48;

   logic clock;
   logic reset;

   mahs_req_if req_chan ();
   mahs_rsp_if rsp_chan ();
   mahs_csr_if csr_chan ();

   mpeg_audio_header_scanner uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   scanner_scoreboard sb;

   int          tx_idle_pct;
   int          rx_idle_pct;
   int          tx_calm;
   int          rx_calm;
   int unsigned bytes_counted;
   int unsigned members_sent;
   int unsigned regs_written;
   logic [7:0]  member_bytes[$];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watch all three channels at the rising edge. Byte words feed the
   // predictor, result words are checked against the oldest expectation,
   // csr writes update the predictor's copy of the registers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_byte(req_chan.data_byte, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check('{status:          rsp_chan.status,
                       header_position: rsp_chan.header_position,
                       version:         rsp_chan.version,
                       layer:           rsp_chan.layer,
                       bitrate_kbps:    rsp_chan.bitrate_kbps,
                       play_length_ms:  rsp_chan.play_length_ms});
         if (csr_chan.valid && csr_chan.ready)
            sb.write_reg(csr_chan.index, csr_chan.data);
      end
   end

   // Result side back-pressure. Now and then a calm stretch keeps ready
   // high so back-to-back results also get exercised.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_calm > 0) begin
            rx_calm--;
            rsp_chan.ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(10, 40);
            rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Byte words go out at the falling edge; the task returns at the edge
   // that accepted the word, so valid stays up if the next one follows.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (tx_calm > 0) begin
         tx_calm--;
      end else begin
         if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(10, 40);
         while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= is_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // member_bytes as one member, last flag on its final byte;
   // trailing bytes after a header are ignored by the block and not counted
   task automatic send_member(input int unsigned ignored);
      for (int i = 0; i < member_bytes.size(); i++)
         send_byte(member_bytes[i], i == member_bytes.size() - 1);
      bytes_counted += member_bytes.size() - ignored;
      members_sent++;
   endtask

   // drop valid, wait for every expected result, then let the divider drain
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      regs_written++;
   endtask

   task automatic configure(input logic [31:0] offset, input logic [31:0] size);
      settle();
      write_reg(CsrMemberOffset, offset);
      write_reg(CsrCompressedSize, size);
   endtask

   // random byte with a heavy share of 0xFF so stray syncs keep turning up
   function automatic logic [7:0] noisy_byte();
      return ($urandom_range(0, 3) == 0) ? SyncByte : 8'($urandom());
   endfunction

   // Mostly well-formed members (junk, sync, header byte, bitrate byte,
   // ignored tail); some cut off at or inside the sync; some pure noise.
   task automatic make_random_member(output int unsigned ignored);
      int unsigned kind;
      int unsigned tail;
      member_bytes.delete();
      ignored = 0;
      kind    = $urandom_range(0, 99);
      if (kind < 70) begin
         repeat ($urandom_range(0, 5)) member_bytes.push_back(noisy_byte());
         member_bytes.push_back(SyncByte);
         member_bytes.push_back(SyncMask | 8'($urandom_range(0, 31)));
         member_bytes.push_back(8'($urandom()));
         tail = $urandom_range(0, 3);
         repeat (tail) member_bytes.push_back(noisy_byte());
         ignored = tail;
      end else if (kind < 85) begin
         repeat ($urandom_range(0, 4)) member_bytes.push_back(noisy_byte());
         member_bytes.push_back(SyncByte);
         if ($urandom_range(0, 1) == 1)
            member_bytes.push_back(SyncMask | 8'($urandom_range(0, 31)));
      end else begin
         repeat ($urandom_range(1, 12)) member_bytes.push_back(noisy_byte());
      end
   endtask

   initial begin
      int unsigned ignored;
      int unsigned target;
      logic [31:0] offset;
      logic [31:0] size;

      sb                 = new();
      tx_idle_pct        = 0;
      rx_idle_pct        = 0;
      tx_calm            = 0;
      rx_calm            = 0;
      bytes_counted      = 0;
      members_sent       = 0;
      regs_written       = 0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed members, full size register for the largest play length
      configure(32'h0000_0000, 32'hFFFF_FFFF);
      member_bytes = '{8'h5A, 8'h12};             send_member(0); // no sync at all
      member_bytes = '{8'hFF, 8'hF3, 8'h10};      send_member(0); // MPEG-2 L3 8 kbps, max length
      member_bytes = '{8'hFF, 8'hFF, 8'hE0, 8'h55};
      send_member(1);                                             // FF FF sync, 448 kbps, tail
      member_bytes = '{8'hFF, 8'hE2};             send_member(0); // ends inside header
      member_bytes = '{8'hFF};                    send_member(0); // sync byte alone, ends
      member_bytes = '{8'hE2};                    send_member(0); // no sync across members
      member_bytes = '{8'hFF, 8'hEA, 8'h90};      send_member(0); // reserved version
      member_bytes = '{8'hFF, 8'hF8, 8'h90};      send_member(0); // reserved layer
      member_bytes = '{8'hFF, 8'hFB, 8'hF0};      send_member(0); // bad bitrate index
      member_bytes = '{8'hFF, 8'hE2, 8'h00};      send_member(0); // MPEG-2.5, free bitrate

      // header position wraps past the top of the offset range
      configure(32'hFFFF_FFFF, 32'h0000_0000);
      member_bytes = '{8'h00, 8'hFF, 8'hFD, 8'h50};
      send_member(0);

      // ---- random members: two settings per back-pressure mode,
      //      first setting of the run at zero, second at all ones
      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin
               tx_idle_pct = 32;
               rx_idle_pct = 77;
            end
            1: begin
               tx_idle_pct = 77;
               rx_idle_pct = 32;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         if (ph == 0) begin
            offset = '0;
            size   = '0;
         end else if (ph == 1) begin
            offset = '1;
            size   = '1;
         end else begin
            offset = $urandom();
            size   = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 1000)) : $urandom();
         end
         configure(offset, size);
         target = bytes_counted + BytesPerPhase;
         while (bytes_counted < target) begin
            make_random_member(ignored);
            send_member(ignored);
         end
      end

      settle();
      $display("Scanned %0d members (%0d counted bytes) over %0d register writes;",
               members_sent, bytes_counted, regs_written);
      $display("matched %0d found headers and %0d not-found results.",
               sb.found_seen, sb.missing_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
